>>> rtl/word_space_line_chopper_defines.svh
// ----------------------------------------------------------------------------
// word_space_line_chopper_defines.svh
// Assertion macros shared by the chopper checker.
// ----------------------------------------------------------------------------
`ifndef WORD_SPACE_LINE_CHOPPER_DEFINES_SVH
`define WORD_SPACE_LINE_CHOPPER_DEFINES_SVH

// Checked only while out of reset.
`define WSLC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define WSLC_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/wslc_pkg.sv
// ----------------------------------------------------------------------------
// wslc_pkg
// Types, codes and constants of the word/space/line chopper.
// ----------------------------------------------------------------------------
`default_nettype none

package wslc_pkg;

  localparam int LINE_COUNT_BITS_DEF = 32;
  localparam int LINE_OUT_BITS       = 32;

  // result queue
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);

  // request actions
  localparam logic [1:0] ACT_CHAR  = 2'd0;
  localparam logic [1:0] ACT_FLUSH = 2'd1;
  localparam logic [1:0] ACT_RESET = 2'd2;

  // chop modes
  localparam logic [1:0] MODE_FMT = 2'd0;
  localparam logic [1:0] MODE_PRE = 2'd1;
  localparam logic [1:0] MODE_STR = 2'd2;

  // phase: A = in word / seen CR, B = in space / seen LF, LINE = line content
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_A    = 2'd1;
  localparam logic [1:0] PH_B    = 2'd2;
  localparam logic [1:0] PH_LINE = 2'd3;

  // end-of-line convention
  localparam logic [1:0] CONV_NONE = 2'd0;
  localparam logic [1:0] CONV_LF   = 2'd1;
  localparam logic [1:0] CONV_CR   = 2'd2;

  localparam logic [7:0] CH_NUL        = 8'h00;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_LF         = 8'h0A;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_WS_LIMIT   = 8'd33;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_DEL        = 8'h7F;

  typedef enum logic [1:0] {
    KIND_CHAR     = 2'd0,
    KIND_WORD_END = 2'd1,
    KIND_SPACE    = 2'd2,
    KIND_EOL      = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] ch;
    logic       last;
  } item_t;

  typedef struct packed {
    kind_t                    kind;
    logic [7:0]               ch;
    logic [LINE_OUT_BITS-1:0] line;
    logic                     last;
  } tok_t;

  typedef struct packed {
    logic [1:0] cnt;
    tok_t       tok0;
    tok_t       tok1;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/wslc_core.sv
// ----------------------------------------------------------------------------
// wslc_core
// Chopper state and token logic: one request in, up to two tokens out.
// ----------------------------------------------------------------------------
`default_nettype none

module wslc_core #(
  parameter int LINE_COUNT_BITS = wslc_pkg::LINE_COUNT_BITS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            adv,
  input  wire wslc_pkg::item_t item,
  input  wire logic [1:0]      mode,
  output wslc_pkg::res_t       res
);

  logic [1:0]                 phase_r, phase_nxt;
  logic [1:0]                 conv_r, conv_nxt;
  logic [LINE_COUNT_BITS-1:0] count_r, count_nxt;

  logic                is_cr, is_lf, is_eol, is_ws, same;
  logic [7:0]          tidy_ch;
  logic [1:0]          n;
  wslc_pkg::kind_t     k0, k1;
  logic [7:0]          c0, c1;
  logic                bump;

  assign is_cr   = (item.ch == wslc_pkg::CH_CR);
  assign is_lf   = (item.ch == wslc_pkg::CH_LF);
  assign is_eol  = is_cr | is_lf;
  assign is_ws   = (item.ch < wslc_pkg::CH_WS_LIMIT) || (item.ch == wslc_pkg::CH_DEL);
  assign same    = (phase_r == wslc_pkg::PH_A) ? is_cr : is_lf;
  // control bytes other than tab show as a dot in preformatted text
  assign tidy_ch = (((item.ch < wslc_pkg::CH_SPACE) && (item.ch != wslc_pkg::CH_TAB)) ||
                    (item.ch == wslc_pkg::CH_DEL)) ? wslc_pkg::CH_DOT : item.ch;

  always_comb begin
    phase_nxt = phase_r;
    conv_nxt  = conv_r;
    bump      = 1'b0;
    n         = 2'd0;
    k0        = wslc_pkg::KIND_CHAR;
    k1        = wslc_pkg::KIND_CHAR;
    c0        = wslc_pkg::CH_NUL;
    c1        = wslc_pkg::CH_NUL;
    case (item.action)
      wslc_pkg::ACT_RESET: begin
        phase_nxt = wslc_pkg::PH_IDLE;
        conv_nxt  = wslc_pkg::CONV_NONE;
      end
      wslc_pkg::ACT_FLUSH: begin
        phase_nxt = wslc_pkg::PH_IDLE;
        case (mode)
          wslc_pkg::MODE_FMT: begin
            if (phase_r == wslc_pkg::PH_A || phase_r == wslc_pkg::PH_LINE) begin
              n  = 2'd1;
              k0 = wslc_pkg::KIND_WORD_END;
            end else if (phase_r == wslc_pkg::PH_B) begin
              n  = 2'd1;
              k0 = wslc_pkg::KIND_SPACE;
            end
          end
          wslc_pkg::MODE_PRE: begin
            if (phase_r == wslc_pkg::PH_A || phase_r == wslc_pkg::PH_B) begin
              n  = 2'd1;
              k0 = wslc_pkg::KIND_EOL;
            end else if (phase_r == wslc_pkg::PH_LINE) begin
              n  = 2'd1;
              k0 = wslc_pkg::KIND_WORD_END;
            end
          end
          default: ;
        endcase
      end
      wslc_pkg::ACT_CHAR: begin
        // line counter learns the convention from the first CR or LF
        case (conv_r)
          wslc_pkg::CONV_LF: bump = is_lf;
          wslc_pkg::CONV_CR: bump = is_cr;
          default: begin
            if (is_lf) begin
              conv_nxt = wslc_pkg::CONV_LF;
              bump     = 1'b1;
            end else if (is_cr) begin
              conv_nxt = wslc_pkg::CONV_CR;
              bump     = 1'b1;
            end
          end
        endcase
        case (mode)
          wslc_pkg::MODE_FMT: begin
            // phase LINE left by preformatted mode counts as in a word
            if (phase_r == wslc_pkg::PH_IDLE) begin
              phase_nxt = is_ws ? wslc_pkg::PH_B : wslc_pkg::PH_A;
              if (!is_ws) begin
                n  = 2'd1;
                c0 = item.ch;
              end
            end else if (phase_r == wslc_pkg::PH_B) begin
              if (!is_ws) begin
                n         = 2'd2;
                k0        = wslc_pkg::KIND_SPACE;
                c1        = item.ch;
                phase_nxt = wslc_pkg::PH_A;
              end
            end else begin
              n = 2'd1;
              if (is_ws) begin
                k0        = wslc_pkg::KIND_WORD_END;
                phase_nxt = wslc_pkg::PH_B;
              end else begin
                c0        = item.ch;
                phase_nxt = wslc_pkg::PH_A;
              end
            end
          end
          wslc_pkg::MODE_PRE: begin
            if (phase_r == wslc_pkg::PH_IDLE) begin
              phase_nxt = is_cr ? wslc_pkg::PH_A :
                          (is_lf ? wslc_pkg::PH_B : wslc_pkg::PH_LINE);
              if (!is_eol) begin
                n  = 2'd1;
                c0 = tidy_ch;
              end
            end else if (phase_r == wslc_pkg::PH_LINE) begin
              n = 2'd1;
              if (is_eol) begin
                k0        = wslc_pkg::KIND_WORD_END;
                phase_nxt = is_cr ? wslc_pkg::PH_A : wslc_pkg::PH_B;
              end else begin
                c0 = tidy_ch;
              end
            end else begin
              // pending CR or LF: a different partner completes the pair
              k0 = wslc_pkg::KIND_EOL;
              if (is_eol) begin
                n = 2'd1;
                if (!same) phase_nxt = wslc_pkg::PH_IDLE;
              end else begin
                n         = 2'd2;
                c1        = tidy_ch;
                phase_nxt = wslc_pkg::PH_LINE;
              end
            end
          end
          default: begin
            if (item.ch != wslc_pkg::CH_NUL) begin
              c0 = item.ch;
              if (item.last) begin
                n  = 2'd2;
                k1 = wslc_pkg::KIND_WORD_END;
              end else begin
                n = 2'd1;
              end
            end else if (item.last) begin
              n  = 2'd1;
              k0 = wslc_pkg::KIND_WORD_END;
            end
          end
        endcase
      end
      default: ;
    endcase
  end

  // saturating line counter
  always_comb begin
    count_nxt = count_r;
    if (bump && (count_r != '1)) count_nxt = count_r + 1'b1;
  end

  always_comb begin
    res.cnt       = n;
    res.tok0.kind = k0;
    res.tok0.ch   = c0;
    res.tok0.line = wslc_pkg::LINE_OUT_BITS'(count_nxt);
    res.tok0.last = (n == 2'd1);
    res.tok1.kind = k1;
    res.tok1.ch   = c1;
    res.tok1.line = wslc_pkg::LINE_OUT_BITS'(count_nxt);
    res.tok1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= wslc_pkg::PH_IDLE;
      conv_r  <= wslc_pkg::CONV_NONE;
      count_r <= '0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      conv_r  <= conv_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/wslc_outq.sv
// ----------------------------------------------------------------------------
// wslc_outq
// Small result queue: takes up to two tokens a cycle, hands out one.
// ----------------------------------------------------------------------------
`default_nettype none

module wslc_outq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire wslc_pkg::res_t push,
  input  wire logic           pop,
  output logic                valid,
  output logic                room2,
  output wslc_pkg::tok_t      head
);

  localparam int CW = wslc_pkg::OQ_AW + 1;

  wslc_pkg::tok_t             mem_r [wslc_pkg::OQ_DEPTH];
  logic [wslc_pkg::OQ_AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]              cnt_r, cnt_nxt, cnt_left;

  assign valid    = (cnt_r != '0);
  assign head     = mem_r[rp_r];
  assign cnt_left = cnt_r - CW'(pop);
  assign room2    = (cnt_left <= CW'(wslc_pkg::OQ_DEPTH - 2));

  always_comb begin
    wp_nxt  = wp_r + wslc_pkg::OQ_AW'(push.cnt);
    rp_nxt  = rp_r + wslc_pkg::OQ_AW'(pop);
    cnt_nxt = cnt_left + CW'(push.cnt);
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem_r[wp_r] <= push.tok0;
    if (push.cnt == 2'd2) mem_r[wp_r + wslc_pkg::OQ_AW'(1)] <= push.tok1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/word_space_line_chopper.sv
// ----------------------------------------------------------------------------
// word_space_line_chopper
// Splits a byte stream into word, space and end-of-line tokens.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per accepted valid/ready beat: a text byte, a flush
//           or a state reset. cfg_* : writes chop_mode, always ready; write
//           it only while the chopper is drained.
//   out_* : tokens in order; out_last_result marks the final token of a
//           request, out_line_number is the line count after that request.
// Flow: an accepted request is registered, waits while the queue lacks room
//   for two tokens, and its tokens then enter the queue shown on out_*.
// Throughput: one request per cycle while each makes at most one token and
//   out_ready stays high; a request with two tokens is handed out one token
//   at a time. Set by the single output port of the four-entry result queue.
// Reset (rst_n low, synchronous): queue empties, mode back to formatted,
//   phase, convention and line count cleared.
// Stall: when out_ready stays low the queue fills and in_ready drops once
//   fewer than two slots would be free; nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module word_space_line_chopper #(
  parameter int LINE_COUNT_BITS = wslc_pkg::LINE_COUNT_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_action,
  input  wire logic [7:0]  in_char_in,
  input  wire logic        in_last_in_call,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_token_kind,
  output logic [7:0]       out_char_out,
  output logic [31:0]      out_line_number,
  output logic             out_last_result,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_chop_mode
);

  wslc_pkg::item_t item_r, item_nxt;
  logic            item_v_r, item_v_nxt;
  logic [1:0]      mode_r;
  logic            adv, room2, pop, in_take;
  wslc_pkg::res_t  res, push;
  wslc_pkg::tok_t  head;

  assign cfg_ready = 1'b1;
  assign pop       = out_valid & out_ready;
  assign adv       = item_v_r & room2;
  assign in_ready  = !item_v_r || adv;
  assign in_take   = in_valid & in_ready;

  always_comb begin
    item_nxt.action = in_action;
    item_nxt.ch     = in_char_in;
    item_nxt.last   = in_last_in_call;
    item_v_nxt      = in_take ? 1'b1 : (adv ? 1'b0 : item_v_r);
    push            = res;
    if (!adv) push.cnt = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (in_take) item_r <= item_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
      mode_r   <= wslc_pkg::MODE_FMT;
    end else begin
      item_v_r <= item_v_nxt;
      if (cfg_valid) mode_r <= cfg_chop_mode;
    end
  end

  wslc_core #(
    .LINE_COUNT_BITS(LINE_COUNT_BITS)
  ) u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .adv  (adv),
    .item (item_r),
    .mode (mode_r),
    .res  (res)
  );

  wslc_outq u_outq (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push),
    .pop  (pop),
    .valid(out_valid),
    .room2(room2),
    .head (head)
  );

  assign out_token_kind  = head.kind;
  assign out_char_out    = head.ch;
  assign out_line_number = head.line;
  assign out_last_result = head.last;

endmodule

`default_nettype wire

>>> rtl/wslc_checker.sv
// ----------------------------------------------------------------------------
// wslc_checker
// Port-level checks on the chopper's token channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "word_space_line_chopper_defines.svh"

module wslc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_token_kind,
  input wire logic [7:0]  out_char_out,
  input wire logic [31:0] out_line_number,
  input wire logic        out_last_result
);

  logic [42:0] out_payload;
  logic        out_stall;
  logic        out_take;
  logic        out_not_char;

  assign out_payload  = {out_token_kind, out_char_out, out_line_number, out_last_result};
  assign out_stall    = out_valid && !out_ready;
  assign out_take     = out_valid && out_ready;
  assign out_not_char = out_valid && (out_token_kind != wslc_pkg::KIND_CHAR);

  `WSLC_ASSERT(a_out_hold, out_stall |=> out_valid && $stable(out_payload), "stalled token changed")

  `WSLC_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "token shown after reset")

  `WSLC_ASSERT(a_char_zero, out_not_char |-> out_char_out == 8'h00, "byte on non-character token")

  // both tokens of a request enter the queue together
  `WSLC_ASSERT(a_pair_follows, out_take && !out_last_result |=> out_valid, "second token missing")

endmodule

bind word_space_line_chopper wslc_checker u_wslc_checker (.*);

`default_nettype wire

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the word/space/line chopper. A driver feeds
// text-byte, flush and reset requests from a queue with bursts and gaps.
// A monitor predicts the token stream for each accepted request and checks
// every output token field by field, in order, while the result side stalls
// on its own pattern. The run covers all chop modes, with mode changes made
// only while the chopper is drained.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [1:0] ACT_UNUSED    = 2'd3;
  localparam logic [1:0] MODE_SPARE    = 2'd3;
  localparam int         CYCLE_LIMIT   = 400000;
  localparam int         LONG_HOLD     = 300;
  localparam int         SETTLE_CYCLES = 6;
  localparam int         PRINT_CAP     = 50;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_action = wslc_pkg::ACT_CHAR;
  logic [7:0]  in_char_in = 8'h00;
  logic        in_last_in_call = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_token_kind;
  logic [7:0]  out_char_out;
  logic [31:0] out_line_number;
  logic        out_last_result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_chop_mode = wslc_pkg::MODE_FMT;

  word_space_line_chopper u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_char_in      (in_char_in),
    .in_last_in_call (in_last_in_call),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_token_kind  (out_token_kind),
    .out_char_out    (out_char_out),
    .out_line_number (out_line_number),
    .out_last_result (out_last_result),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_chop_mode   (cfg_chop_mode)
  );

  // predicted chopper state
  logic [1:0]  chop_mode_q  = wslc_pkg::MODE_FMT;
  logic [1:0]  phase_q      = wslc_pkg::PH_IDLE;
  logic [1:0]  eol_conv_q   = wslc_pkg::CONV_NONE;
  logic [31:0] line_count_q = '0;

  wslc_pkg::item_t pending_requests[$];
  wslc_pkg::tok_t  expected_tokens[$];
  int unsigned requests_queued   = 0;
  int unsigned requests_accepted = 0;
  int unsigned mismatch_count    = 0;
  int unsigned cycle_count       = 0;
  logic        in_fired = 1'b0;
  logic        hold_request = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      cycle_count <= cycle_count + 1;
    end
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatch_count < PRINT_CAP)
      $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  function automatic wslc_pkg::tok_t make_token(wslc_pkg::kind_t k, logic [7:0] c);
    wslc_pkg::tok_t t;
    t.kind = k;
    t.ch   = (k == wslc_pkg::KIND_CHAR) ? c : 8'h00;
    t.line = '0;
    t.last = 1'b0;
    return t;
  endfunction

  // Works out the tokens of one request and updates the predicted state.
  function automatic void chop_request(wslc_pkg::item_t req);
    wslc_pkg::tok_t toks[$];
    logic [7:0]     c;
    logic           cr, lf, ws;
    logic [1:0]     ph;
    c  = req.ch;
    cr = (c == wslc_pkg::CH_CR);
    lf = (c == wslc_pkg::CH_LF);
    if (req.action == wslc_pkg::ACT_RESET) begin
      phase_q    = wslc_pkg::PH_IDLE;
      eol_conv_q = wslc_pkg::CONV_NONE;
      return;
    end
    if (req.action == ACT_UNUSED)
      return;

    if (req.action == wslc_pkg::ACT_FLUSH) begin
      if (chop_mode_q == wslc_pkg::MODE_FMT) begin
        if (phase_q == wslc_pkg::PH_A || phase_q == wslc_pkg::PH_LINE)
          toks.push_back(make_token(wslc_pkg::KIND_WORD_END, 8'h00));
        else if (phase_q == wslc_pkg::PH_B)
          toks.push_back(make_token(wslc_pkg::KIND_SPACE, 8'h00));
      end else if (chop_mode_q == wslc_pkg::MODE_PRE) begin
        if (phase_q == wslc_pkg::PH_A || phase_q == wslc_pkg::PH_B)
          toks.push_back(make_token(wslc_pkg::KIND_EOL, 8'h00));
        else if (phase_q == wslc_pkg::PH_LINE)
          toks.push_back(make_token(wslc_pkg::KIND_WORD_END, 8'h00));
      end
      phase_q = wslc_pkg::PH_IDLE;
    end else begin
      // line counter learns the convention from the first CR or LF
      if ((eol_conv_q == wslc_pkg::CONV_LF && lf) ||
          (eol_conv_q == wslc_pkg::CONV_CR && cr) ||
          (eol_conv_q == wslc_pkg::CONV_NONE && (cr || lf))) begin
        if (eol_conv_q == wslc_pkg::CONV_NONE)
          eol_conv_q = lf ? wslc_pkg::CONV_LF : wslc_pkg::CONV_CR;
        if (line_count_q != '1)
          line_count_q++;
      end

      if (chop_mode_q == wslc_pkg::MODE_FMT) begin
        ws = (c < wslc_pkg::CH_WS_LIMIT) || (c == wslc_pkg::CH_DEL);
        ph = (phase_q == wslc_pkg::PH_LINE) ? wslc_pkg::PH_A : phase_q;
        if (ph == wslc_pkg::PH_IDLE) begin
          phase_q = ws ? wslc_pkg::PH_B : wslc_pkg::PH_A;
          if (!ws)
            toks.push_back(make_token(wslc_pkg::KIND_CHAR, c));
        end else if (ph == wslc_pkg::PH_A) begin
          if (ws) begin
            toks.push_back(make_token(wslc_pkg::KIND_WORD_END, 8'h00));
            phase_q = wslc_pkg::PH_B;
          end else begin
            phase_q = wslc_pkg::PH_A;
            toks.push_back(make_token(wslc_pkg::KIND_CHAR, c));
          end
        end else if (!ws) begin
          toks.push_back(make_token(wslc_pkg::KIND_SPACE, 8'h00));
          phase_q = wslc_pkg::PH_A;
          toks.push_back(make_token(wslc_pkg::KIND_CHAR, c));
        end
      end else if (chop_mode_q == wslc_pkg::MODE_PRE) begin
        case (phase_q)
          wslc_pkg::PH_IDLE:
            phase_q = cr ? wslc_pkg::PH_A : (lf ? wslc_pkg::PH_B : wslc_pkg::PH_LINE);
          wslc_pkg::PH_A, wslc_pkg::PH_B: begin
            toks.push_back(make_token(wslc_pkg::KIND_EOL, 8'h00));
            // CRLF and LFCR close as one line end; a repeat starts another
            if (cr || lf) begin
              if (!((phase_q == wslc_pkg::PH_A) ? cr : lf))
                phase_q = wslc_pkg::PH_IDLE;
            end else begin
              phase_q = wslc_pkg::PH_LINE;
            end
          end
          default: begin
            if (cr || lf) begin
              toks.push_back(make_token(wslc_pkg::KIND_WORD_END, 8'h00));
              phase_q = cr ? wslc_pkg::PH_A : wslc_pkg::PH_B;
            end
          end
        endcase
        if (!cr && !lf)
          toks.push_back(make_token(wslc_pkg::KIND_CHAR,
              ((c < wslc_pkg::CH_SPACE && c != wslc_pkg::CH_TAB) ||
               c == wslc_pkg::CH_DEL) ? wslc_pkg::CH_DOT : c));
      end else begin
        if (c != wslc_pkg::CH_NUL)
          toks.push_back(make_token(wslc_pkg::KIND_CHAR, c));
        if (req.last)
          toks.push_back(make_token(wslc_pkg::KIND_WORD_END, 8'h00));
      end
    end

    foreach (toks[i]) begin
      toks[i].line = line_count_q;
      toks[i].last = (i == toks.size() - 1);
      expected_tokens.push_back(toks[i]);
    end
  endfunction

  // monitor: config, result check and prediction at the rising edge
  always @(posedge clk) begin
    wslc_pkg::tok_t  want;
    wslc_pkg::item_t req;
    if (!rst_n) begin
      in_fired <= 1'b0;
    end else begin
      in_fired <= in_valid && in_ready;
      if (cfg_valid && cfg_ready)
        chop_mode_q = cfg_chop_mode;
      if (out_valid && out_ready) begin
        if (expected_tokens.size() == 0) begin
          report_mismatch("token with none expected", out_token_kind, 0);
        end else begin
          want = expected_tokens.pop_front();
          if (out_token_kind != want.kind)
            report_mismatch("token_kind", out_token_kind, want.kind);
          if (out_char_out != want.ch)
            report_mismatch("char_out", out_char_out, want.ch);
          if (out_line_number != want.line)
            report_mismatch("line_number", out_line_number, want.line);
          if (out_last_result != want.last)
            report_mismatch("last_result", out_last_result, want.last);
        end
      end
      if (in_valid && in_ready) begin
        req.action = in_action;
        req.ch     = in_char_in;
        req.last   = in_last_in_call;
        chop_request(req);
        requests_accepted++;
      end
    end
  end

  // request driver: bursts of random length, random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(negedge clk) begin
    wslc_pkg::item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fired) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_requests.size() != 0) begin
        nxt = pending_requests.pop_front();
        in_valid        <= 1'b1;
        in_action       <= nxt.action;
        in_char_in      <= nxt.ch;
        in_last_in_call <= nxt.last;
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(0, 8);
          gap_left   = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 20)
                                                   : $urandom_range(0, 4);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side: stall pattern follows bits 8 to 6 of rx_cycle, plus one long hold
  int unsigned rx_cycle  = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  always @(negedge clk) begin
    rx_cycle++;
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_request && !hold_done) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD;
      out_ready <= 1'b0;
    end else begin
      case (rx_cycle[8:6])
        3'd0, 3'd1: out_ready <= 1'b1;
        3'd2, 3'd3: out_ready <= 1'($urandom_range(0, 1));
        3'd4:       out_ready <= ($urandom_range(0, 3) == 0);
        3'd5:       out_ready <= rx_cycle[1];
        default:    out_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  task automatic push_req(logic [1:0] action, logic [7:0] c, logic last);
    wslc_pkg::item_t it;
    it.action = action;
    it.ch     = c;
    it.last   = last;
    pending_requests.push_back(it);
    requests_queued++;
  endtask

  function automatic logic [7:0] word_byte();
    return ($urandom_range(0, 5) == 0) ? 8'($urandom_range(128, 255))
                                       : 8'($urandom_range(33, 126));
  endfunction

  function automatic logic [7:0] sep_byte();
    case ($urandom_range(0, 4))
      0:       return wslc_pkg::CH_SPACE;
      1:       return wslc_pkg::CH_TAB;
      2:       return wslc_pkg::CH_DEL;
      3:       return wslc_pkg::CH_NUL;
      default: return 8'($urandom_range(0, 32));
    endcase
  endfunction

  // Random text built mostly from words, separator runs, line breaks and
  // string groups, with some noise, flushes and state resets mixed in.
  task automatic queue_text(int count, logic [1:0] mode);
    int n;
    int len;
    int pick;
    n = 0;
    while (n < count) begin
      pick = $urandom_range(0, 99);
      if (mode >= wslc_pkg::MODE_STR && pick < 60)
        pick = 75 + pick % 10;
      if (pick < 40) begin
        len = $urandom_range(1, 8);
        repeat (len) push_req(wslc_pkg::ACT_CHAR, word_byte(), 1'b0);
        n += len;
      end else if (pick < 60) begin
        len = $urandom_range(1, 3);
        repeat (len) push_req(wslc_pkg::ACT_CHAR, sep_byte(), 1'b0);
        n += len;
      end else if (pick < 75) begin
        case ($urandom_range(0, 3))
          0: push_req(wslc_pkg::ACT_CHAR, wslc_pkg::CH_CR, 1'b0);
          1: push_req(wslc_pkg::ACT_CHAR, wslc_pkg::CH_LF, 1'b0);
          2: begin
            push_req(wslc_pkg::ACT_CHAR, wslc_pkg::CH_CR, 1'b0);
            push_req(wslc_pkg::ACT_CHAR, wslc_pkg::CH_LF, 1'b0);
          end
          default: begin
            push_req(wslc_pkg::ACT_CHAR, wslc_pkg::CH_LF, 1'b0);
            push_req(wslc_pkg::ACT_CHAR, wslc_pkg::CH_CR, 1'b0);
          end
        endcase
        n += 2;
      end else if (pick < 85) begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
          push_req(wslc_pkg::ACT_CHAR,
                   ($urandom_range(0, 9) == 0) ? wslc_pkg::CH_NUL : word_byte(),
                   i == len - 1);
        n += len;
      end else if (pick < 93) begin
        push_req(wslc_pkg::ACT_CHAR, 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)));
        n++;
      end else if (pick < 97) begin
        push_req(wslc_pkg::ACT_FLUSH, 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)));
        n++;
      end else if (pick < 99) begin
        push_req(wslc_pkg::ACT_RESET, 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)));
        n++;
      end else begin
        push_req(ACT_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Returns at a falling edge once every request is in and every token out.
  task automatic wait_drained();
    @(negedge clk);
    while (requests_accepted != requests_queued || expected_tokens.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_mode(logic [1:0] m);
    cfg_chop_mode <= m;
    cfg_valid     <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // formatted mode out of reset: byte extremes, separators, flushes
    push_req(wslc_pkg::ACT_CHAR, "a", 1'b0);
    push_req(wslc_pkg::ACT_CHAR, 8'hFF, 1'b1);
    push_req(wslc_pkg::ACT_CHAR, wslc_pkg::CH_SPACE, 1'b0);
    push_req(wslc_pkg::ACT_CHAR, wslc_pkg::CH_NUL, 1'b0);
    push_req(wslc_pkg::ACT_CHAR, wslc_pkg::CH_DEL, 1'b0);
    push_req(wslc_pkg::ACT_CHAR, 8'h21, 1'b0);
    push_req(wslc_pkg::ACT_FLUSH, 8'h00, 1'b0);
    push_req(wslc_pkg::ACT_CHAR, wslc_pkg::CH_SPACE, 1'b0);
    push_req(wslc_pkg::ACT_FLUSH, 8'hFF, 1'b1);
    push_req(wslc_pkg::ACT_CHAR, wslc_pkg::CH_LF, 1'b0);
    push_req(wslc_pkg::ACT_CHAR, wslc_pkg::CH_CR, 1'b0);
    push_req(wslc_pkg::ACT_FLUSH, 8'h00, 1'b0);
    push_req(ACT_UNUSED, 8'h41, 1'b0);
    push_req(wslc_pkg::ACT_RESET, 8'h00, 1'b0);
    queue_text(110, wslc_pkg::MODE_FMT);
    wait_drained();

    // string mode: dropped NUL still closes the word
    write_mode(wslc_pkg::MODE_STR);
    push_req(wslc_pkg::ACT_CHAR, wslc_pkg::CH_NUL, 1'b1);
    push_req(wslc_pkg::ACT_CHAR, "z", 1'b0);
    push_req(wslc_pkg::ACT_CHAR, 8'hFF, 1'b1);
    push_req(wslc_pkg::ACT_FLUSH, 8'h00, 1'b0);
    push_req(wslc_pkg::ACT_CHAR, wslc_pkg::CH_CR, 1'b0);
    queue_text(100, wslc_pkg::MODE_STR);
    wait_drained();

    // preformatted: control bytes, CRLF, LFCR, repeated CR
    write_mode(wslc_pkg::MODE_PRE);
    push_req(wslc_pkg::ACT_CHAR, 8'h01, 1'b0);
    push_req(wslc_pkg::ACT_CHAR, wslc_pkg::CH_TAB, 1'b0);
    push_req(wslc_pkg::ACT_CHAR, wslc_pkg::CH_CR, 1'b0);
    push_req(wslc_pkg::ACT_CHAR, wslc_pkg::CH_LF, 1'b0);
    push_req(wslc_pkg::ACT_CHAR, wslc_pkg::CH_LF, 1'b0);
    push_req(wslc_pkg::ACT_CHAR, wslc_pkg::CH_CR, 1'b0);
    push_req(wslc_pkg::ACT_CHAR, wslc_pkg::CH_CR, 1'b0);
    push_req(wslc_pkg::ACT_CHAR, wslc_pkg::CH_CR, 1'b0);
    push_req(wslc_pkg::ACT_CHAR, "x", 1'b0);
    push_req(wslc_pkg::ACT_CHAR, wslc_pkg::CH_LF, 1'b0);
    push_req(wslc_pkg::ACT_FLUSH, 8'h00, 1'b0);
    push_req(wslc_pkg::ACT_CHAR, wslc_pkg::CH_DEL, 1'b0);
    push_req(wslc_pkg::ACT_FLUSH, 8'h00, 1'b0);
    queue_text(140, wslc_pkg::MODE_PRE);
    // leave line content open for the next mode
    push_req(wslc_pkg::ACT_CHAR, "q", 1'b0);
    wait_drained();

    // formatted again, starting inside line content; long result hold
    write_mode(wslc_pkg::MODE_FMT);
    push_req(wslc_pkg::ACT_CHAR, "r", 1'b0);
    push_req(wslc_pkg::ACT_CHAR, wslc_pkg::CH_SPACE, 1'b0);
    queue_text(130, wslc_pkg::MODE_FMT);
    hold_request <= 1'b1;
    wait_drained();

    write_mode(MODE_SPARE);
    queue_text(60, MODE_SPARE);
    wait_drained();

    write_mode(wslc_pkg::MODE_PRE);
    queue_text(70, wslc_pkg::MODE_PRE);
    wait_drained();
    queue_text(70, wslc_pkg::MODE_PRE);
    wait_drained();

    write_mode(wslc_pkg::MODE_FMT);
    queue_text(40, wslc_pkg::MODE_FMT);
    wait_drained();

    if (mismatch_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/wslc_pkg.sv
rtl/wslc_core.sv
rtl/wslc_outq.sv
rtl/word_space_line_chopper.sv
rtl/wslc_checker.sv
bench/tb_top.sv
